// ===== hw/rtl/tcon_pkg.sv =====
// Package for the text console: payload structs, byte codes and the front-to-back op format.
// No dependencies.
`timescale 1ns / 1ps
package tcon_pkg;

   typedef struct packed {
      logic        func;
      logic [7:0]  char_byte;
      logic [10:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [15:0] cell_data;
      logic [6:0]  cursor_col;
      logic [4:0]  cursor_row;
      logic [10:0] cursor_pos;
      logic [2:0]  fg_now;
      logic [2:0]  bg_now;
   } rsp_type;

   // Operation codes sent from the parser to the executor.
   localparam logic [2:0] OP_NONE = 3'd0;
   localparam logic [2:0] OP_PUT  = 3'd1;
   localparam logic [2:0] OP_MOVE = 3'd2;
   localparam logic [2:0] OP_READ = 3'd3;

   localparam logic [7:0] CH_ESC   = 8'h1B;
   localparam logic [7:0] CH_LBRK  = 8'h5B;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_SGR   = 8'h6D;
   localparam logic [7:0] CH_CUP_H = 8'h48;
   localparam logic [7:0] CH_CUP_F = 8'h66;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_NUL   = 8'h00;

   localparam logic [9:0] FIELD_MAX = 10'd1023;
   localparam logic [2:0] FG_RESET  = 3'd7;
   localparam logic [2:0] BG_RESET  = 3'd0;

   // One classified beat: colors are already resolved by the parser.
   typedef struct packed {
      logic [2:0]  op;
      logic [7:0]  ch;
      logic [10:0] index;
      logic [9:0]  row;
      logic [9:0]  col;
      logic [2:0]  fg;
      logic [2:0]  bg;
   } op_type;

endpackage

// ===== hw/rtl/tcon_front.sv =====
// Escape parser front end: accepts request beats and turns them into executor ops.
// Depends on tcon_pkg.
`timescale 1ns / 1ps
module tcon_front #(
   parameter int PARAM_BUFFER = 16,
   parameter int MAX_FIELDS   = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tcon_pkg::req_type req_data,
   output logic              op_valid,
   input  logic              op_stall,
   output tcon_pkg::op_type  op_data
);
   import tcon_pkg::*;

   localparam int FW = $clog2(MAX_FIELDS + 1);
   localparam int FI = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
   localparam int SW = $clog2(PARAM_BUFFER);

   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_ESC    = 2'd1;
   localparam logic [1:0] MODE_CSI    = 2'd2;
   // A final 'm' walks the fields, one per cycle.
   localparam logic [1:0] MODE_SGR    = 2'd3;

   logic [1:0]    mode_ff, mode_in;
   logic [SW-1:0] stored_ff, stored_in;
   logic [9:0]    field_ff [MAX_FIELDS];
   logic [9:0]    field_in [MAX_FIELDS];
   logic [FW-1:0] count_ff, count_in;
   logic          open_ff, open_in;
   logic [FW-1:0] walk_ff, walk_in;
   logic [2:0]    fg_ff, fg_in, bg_ff, bg_in;
   op_type        out_ff, out_in;
   logic          out_valid_ff, out_valid_in;

   logic          take;
   logic [7:0]    ch;
   logic [9:0]    cur;
   logic [13:0]   grown;
   logic [9:0]    code;

   assign req_stall = (mode_ff == MODE_SGR) || (out_valid_ff && op_stall);
   assign take      = req_valid && !req_stall;
   assign ch        = req_data.char_byte;
   assign op_valid  = out_valid_ff;
   assign op_data   = out_ff;

   assign cur   = field_ff[FI'(count_ff - FW'(1))];
   assign grown = {4'd0, cur} * 14'd10 + {10'd0, ch[3:0]};
   assign code  = field_ff[FI'(walk_ff)];

   // Parser state update and op generation.
   always_comb begin
      mode_in      = mode_ff;
      stored_in    = stored_ff;
      field_in     = field_ff;
      count_in     = count_ff;
      open_in      = open_ff;
      walk_in      = walk_ff;
      fg_in        = fg_ff;
      bg_in        = bg_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && op_stall;
      if (mode_ff == MODE_SGR) begin
         if (walk_ff >= count_ff) begin
            // The walk is done: the op for the 'm' leaves with the new colors.
            mode_in      = MODE_NORMAL;
            out_in.fg    = fg_ff;
            out_in.bg    = bg_ff;
            out_valid_in = 1'b1;
         end else begin
            if (code == 10'd0) begin
               fg_in = FG_RESET;
               bg_in = BG_RESET;
            end else if (code >= 10'd30 && code <= 10'd37) begin
               fg_in = 3'(code - 10'd30);
            end else if (code >= 10'd40 && code <= 10'd47) begin
               bg_in = 3'(code - 10'd40);
            end
            walk_in = walk_ff + FW'(1);
         end
      end else if (take) begin
         out_in.op    = OP_NONE;
         out_in.ch    = ch;
         out_in.index = req_data.cell_index;
         out_in.row   = 10'd1;
         out_in.col   = 10'd1;
         out_in.fg    = fg_ff;
         out_in.bg    = bg_ff;
         out_valid_in = 1'b1;
         if (req_data.func) begin
            out_in.op = OP_READ;
         end else if (ch == CH_NUL) begin
            mode_in = MODE_NORMAL;
         end else if (mode_ff == MODE_ESC) begin
            if (ch == CH_LBRK) begin
               mode_in   = MODE_CSI;
               stored_in = '0;
               count_in  = '0;
               open_in   = 1'b1;
               for (int i = 0; i < MAX_FIELDS; i++) field_in[i] = '0;
            end else begin
               mode_in = MODE_NORMAL;
            end
         end else if (mode_ff == MODE_CSI) begin
            if ((ch >= CH_ZERO && ch <= CH_NINE) || ch == CH_SEMI) begin
               if (32'(stored_ff) < PARAM_BUFFER - 1) begin
                  stored_in = stored_ff + SW'(1);
                  if (!(open_ff && 32'(count_ff) >= MAX_FIELDS)) begin
                     if (ch == CH_SEMI) begin
                        if (open_ff) count_in = count_ff + FW'(1);
                        open_in = 1'b1;
                     end else if (open_ff) begin
                        count_in = count_ff + FW'(1);
                        open_in  = 1'b0;
                        field_in[FI'(count_ff)] = {6'd0, ch[3:0]};
                     end else begin
                        field_in[FI'(count_ff - FW'(1))] =
                           (grown > 14'(FIELD_MAX)) ? FIELD_MAX : grown[9:0];
                     end
                  end
               end
            end else if (ch == CH_SGR) begin
               mode_in      = MODE_SGR;
               walk_in      = '0;
               out_valid_in = 1'b0;
            end else begin
               mode_in = MODE_NORMAL;
               if (ch == CH_CUP_H || ch == CH_CUP_F) begin
                  out_in.op  = OP_MOVE;
                  out_in.row = (count_ff > FW'(0)) ? field_ff[0] : 10'd1;
                  out_in.col = (count_ff > FW'(1)) ? field_ff[1] : 10'd1;
               end
            end
         end else begin
            if (ch == CH_ESC) mode_in = MODE_ESC;
            else out_in.op = OP_PUT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_NORMAL;
         stored_ff    <= '0;
         count_ff     <= '0;
         open_ff      <= 1'b1;
         walk_ff      <= '0;
         fg_ff        <= FG_RESET;
         bg_ff        <= BG_RESET;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_FIELDS; i++) field_ff[i] <= '0;
      end else begin
         mode_ff      <= mode_in;
         stored_ff    <= stored_in;
         count_ff     <= count_in;
         open_ff      <= open_in;
         walk_ff      <= walk_in;
         fg_ff        <= fg_in;
         bg_ff        <= bg_in;
         out_valid_ff <= out_valid_in;
         field_ff     <= field_in;
      end
      out_ff <= out_in;
   end

   // The field count never exceeds the configured number of fields.
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= MAX_FIELDS) else $error("field count overflow");
   // While the SGR walk runs, no new beat is accepted.
   a_walk_hold: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_SGR) |-> req_stall) else $error("beat taken during SGR");
   // An op held under stall keeps its contents.
   a_op_hold: assert property (@(posedge clock) disable iff (reset)
      (op_valid && op_stall) |=> (op_valid && $stable(op_data)))
      else $error("op changed under stall");
endmodule

// ===== hw/rtl/tcon_back.sv =====
// Executor back end: owns the cell store and cursor, runs ops, scrolls and the clearing pass.
// Depends on tcon_pkg.
`timescale 1ns / 1ps
module tcon_back #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              op_valid,
   output logic              op_stall,
   input  tcon_pkg::op_type  op_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tcon_pkg::rsp_type rsp_data
);
   import tcon_pkg::*;

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_SCROLL = 3'd2;
   localparam logic [2:0] ST_BLANK  = 3'd3;
   localparam logic [2:0] ST_READ   = 3'd4;
   localparam logic [2:0] ST_WSTEP  = 3'd5;

   logic [15:0]   mem [CELLS];
   logic [15:0]   rdata_ff;
   logic          we;
   logic [AW-1:0] waddr, raddr;
   logic [15:0]   wdata;

   logic [2:0]    state_ff, state_in;
   logic [AW:0]   ptr_ff, ptr_in;
   logic [6:0]    col_ff, col_in;
   logic [4:0]    row_ff, row_in;
   logic [2:0]    fg_ff, fg_in, bg_ff, bg_in;
   logic [AW-1:0] base_ff, base_in;
   logic          inr_ff, inr_in;
   logic          rv_ff, rv_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   cell_ff, cell_in;
   logic [15:0]   blank;
   logic          busy;

   assign blank     = {1'b0, bg_ff, 1'b0, fg_ff, CH_SPACE};
   assign busy      = rsp_valid_ff && rsp_stall;
   assign op_stall  = (state_ff != ST_IDLE) || busy;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      rsp_data.cell_data  = cell_ff;
      rsp_data.cursor_col = col_ff;
      rsp_data.cursor_row = row_ff;
      rsp_data.cursor_pos = 11'(base_ff) + 11'(col_ff);
      rsp_data.fg_now     = fg_ff;
      rsp_data.bg_now     = bg_ff;
   end

   // Executor sequencer.
   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      fg_in        = fg_ff;
      bg_in        = bg_ff;
      base_in      = base_ff;
      inr_in       = inr_ff;
      rv_in        = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cell_in      = cell_ff;
      we           = 1'b0;
      waddr        = ptr_ff[AW-1:0];
      wdata        = 16'd0;
      raddr        = ptr_ff[AW-1:0];
      case (state_ff)
         ST_CLEAR: begin
            we     = 1'b1;
            ptr_in = ptr_ff + 1'b1;
            if (32'(ptr_ff) == CELLS - 1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (op_valid && !busy) begin
               fg_in   = op_data.fg;
               bg_in   = op_data.bg;
               cell_in = 16'd0;
               case (op_data.op)
                  OP_READ: begin
                     raddr  = op_data.index[AW-1:0];
                     inr_in = 32'(op_data.index) < CELLS;
                     state_in = ST_READ;
                  end
                  OP_MOVE: begin
                     row_in  = (op_data.row == 10'd0) ? 5'd0 :
                               (32'(op_data.row) > ROWS) ? 5'(ROWS - 1) :
                               5'(op_data.row - 10'd1);
                     col_in  = (op_data.col == 10'd0) ? 7'd0 :
                               (32'(op_data.col) > COLUMNS) ? 7'(COLUMNS - 1) :
                               7'(op_data.col - 10'd1);
                     state_in = ST_WSTEP;
                  end
                  OP_PUT: begin
                     if (op_data.ch == CH_CR) begin
                        col_in = 7'd0;
                        rsp_valid_in = 1'b1;
                     end else if (op_data.ch == CH_LF) begin
                        col_in = 7'd0;
                        if (32'(row_ff) == ROWS - 1) begin
                           ptr_in = '0;
                           state_in = ST_SCROLL;
                        end else begin
                           row_in  = row_ff + 5'd1;
                           base_in = base_ff + AW'(COLUMNS);
                           rsp_valid_in = 1'b1;
                        end
                     end else if (op_data.ch == CH_BS) begin
                        we = 1'b1;
                        wdata = {1'b0, op_data.bg, 1'b0, op_data.fg, CH_SPACE};
                        if (col_ff != 7'd0) begin
                           col_in = col_ff - 7'd1;
                           waddr  = base_ff + AW'(col_ff) - AW'(1);
                        end else if (row_ff != 5'd0) begin
                           row_in  = row_ff - 5'd1;
                           col_in  = 7'(COLUMNS - 1);
                           base_in = base_ff - AW'(COLUMNS);
                           waddr   = base_ff - AW'(1);
                        end else begin
                           waddr = base_ff;
                        end
                        rsp_valid_in = 1'b1;
                     end else begin
                        we    = 1'b1;
                        waddr = base_ff + AW'(col_ff);
                        wdata = {1'b0, op_data.bg, 1'b0, op_data.fg, op_data.ch};
                        if (32'(col_ff) == COLUMNS - 1) begin
                           col_in = 7'd0;
                           if (32'(row_ff) == ROWS - 1) begin
                              ptr_in = '0;
                              state_in = ST_SCROLL;
                           end else begin
                              row_in  = row_ff + 5'd1;
                              base_in = base_ff + AW'(COLUMNS);
                              rsp_valid_in = 1'b1;
                           end
                        end else begin
                           col_in = col_ff + 7'd1;
                           rsp_valid_in = 1'b1;
                        end
                     end
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         ST_WSTEP: begin
            base_in  = AW'(32'(row_ff) * COLUMNS);
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         ST_READ: begin
            cell_in  = inr_ff ? rdata_ff : 16'd0;
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         ST_SCROLL: begin
            // Read cell ptr+COLUMNS; write it to ptr in the next cycle, from the registered read data.
            raddr = AW'(ptr_ff) + AW'(COLUMNS);
            rv_in = 1'b1;
            if (rv_ff) begin
               we    = 1'b1;
               waddr = AW'(ptr_ff) - AW'(1);
               wdata = rdata_ff;
            end
            if (32'(ptr_ff) == CELLS - COLUMNS) begin
               rv_in = 1'b0;
               we    = rv_ff;
               ptr_in = (AW+1)'(CELLS - COLUMNS);
               state_in = ST_BLANK;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         ST_BLANK: begin
            we     = 1'b1;
            waddr  = ptr_ff[AW-1:0];
            wdata  = blank;
            ptr_in = ptr_ff + 1'b1;
            if (32'(ptr_ff) == CELLS - 1) begin
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Cell store, one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ptr_ff       <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         base_ff      <= '0;
         fg_ff        <= FG_RESET;
         bg_ff        <= BG_RESET;
         rv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         base_ff      <= base_in;
         fg_ff        <= fg_in;
         bg_ff        <= bg_in;
         rv_ff        <= rv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      inr_ff  <= inr_in;
      cell_ff <= cell_in;
   end

   // The cursor stays on the screen.
   a_row: assert property (@(posedge clock) disable iff (reset)
      32'(row_ff) < ROWS && 32'(col_ff) < COLUMNS) else $error("cursor off screen");
   // Row base tracks the row when idle.
   a_base: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (32'(base_ff) == 32'(row_ff) * COLUMNS))
      else $error("row base out of step");
   // A response leaves only from idle or the last step of an op.
   a_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff != ST_CLEAR && state_ff != ST_SCROLL))
      else $error("response during sweep");
endmodule

// ===== hw/rtl/tcon_queue.sv =====
// Two-entry queue between parser and executor.
// Depends on tcon_pkg.
`timescale 1ns / 1ps
module tcon_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_stall,
   input  tcon_pkg::op_type in_data,
   output logic             out_valid,
   input  logic             out_stall,
   output tcon_pkg::op_type out_data
);
   import tcon_pkg::*;

   op_type    slot_ff [2];
   logic      wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic      push, pop;

   assign in_stall  = (cnt_ff == 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = slot_ff[rp_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;

   // Pointer and fill bookkeeping.
   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) slot_ff[wp_ff] <= in_data;
   end

   a_fill: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'd2) else $error("queue overfill");
   a_ptr: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0 || cnt_ff == 2'd2) |-> (wp_ff == rp_ff)) else $error("pointer skew");
   a_nopush: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2) |-> !push) else $error("push when full");
endmodule

// ===== hw/rtl/text_console_with_ansi_escapes.sv =====
// Top level of the text console: parser front end, op queue and executor back end.
// Depends on tcon_pkg, tcon_front, tcon_queue and tcon_back.
//
//   Channel | Ports                            | Direction
//   req     | req_valid, req_stall, req_data   | in
//   rsp     | rsp_valid, rsp_stall, rsp_data   | out
//
// An ordinary byte is handled from idle; a read or a cursor move passes through a second state.
// Both the parser output and the queue are registered between a beat and the executor.
// A final 'm' walks the parameter fields in the parser, one field per cycle, then sends its op.
// A scroll copies each row up through the cell store's read and write ports, then blanks the last row.
// After reset a clearing pass writes every cell before the first op executes.
// Each side stalls on its own; the queue and output register keep every beat.
`timescale 1ns / 1ps
module text_console_with_ansi_escapes #(
   parameter int COLUMNS      = 80,
   parameter int ROWS         = 25,
   parameter int PARAM_BUFFER = 16,
   parameter int MAX_FIELDS   = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tcon_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tcon_pkg::rsp_type rsp_data
);
   import tcon_pkg::*;

   op_type f_data, b_data;
   logic   f_valid, f_stall, b_valid, b_stall;

   tcon_front #(.PARAM_BUFFER(PARAM_BUFFER), .MAX_FIELDS(MAX_FIELDS)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .op_valid(f_valid), .op_stall(f_stall), .op_data(f_data));

   tcon_queue u_queue (
      .clock, .reset, .in_valid(f_valid), .in_stall(f_stall), .in_data(f_data),
      .out_valid(b_valid), .out_stall(b_stall), .out_data(b_data));

   tcon_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
      .clock, .reset, .op_valid(b_valid), .op_stall(b_stall), .op_data(b_data),
      .rsp_valid, .rsp_stall, .rsp_data);

   a_resp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid) else $error("response dropped");
   a_req_rst: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response right after reset");
   a_data_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(rsp_data)) else $error("response changed");
endmodule
